>>> hdl/eda_pkg.sv
// Shared constants, types and state encodings for the Euclidean distance accumulator.
`timescale 1ns / 1ps

package eda_pkg;

  // Width of the running sum of squares and of its square root.
  localparam int SUM_W = 40;
  localparam int ROOT_W = 20;

  // Default component width and depth of the queue of finished sums.
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  // Fill status of the sum queue, seen by both the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } back_state_t;

endpackage

>>> hdl/eda_front.sv
// Front end: takes component pairs, squares their difference and keeps the running sum.
`timescale 1ns / 1ps

module eda_front
  import eda_pkg::*;
#(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ELEM_WIDTH-1:0] comp_a,
  input  logic [ELEM_WIDTH-1:0] comp_b,
  input  logic                  last_comp,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  q_status_t             q_stat,
  output logic                  push,
  output logic [SUM_W-1:0]      push_data
);

  localparam int DW = ELEM_WIDTH + 1;
  localparam int SQW = 2 * ELEM_WIDTH;
  localparam int AW = ((SQW > SUM_W) ? SQW : SUM_W) + 1;

  logic [DW-1:0]         diff;
  logic [DW-1:0]         diff_neg;
  logic [ELEM_WIDTH-1:0] mag;
  logic [SQW-1:0]        prod;
  logic [AW-1:0]         total;
  logic [SUM_W-1:0]      acc_sum;
  logic                  adv;

  logic                  v1;
  logic                  last1;
  logic [ELEM_WIDTH-1:0] mag1;
  logic                  v2;
  logic                  last2;
  logic [SQW-1:0]        sq2;
  logic [SUM_W-1:0]      sum;

  // The difference of two W-bit signed values has a magnitude below 2^W.
  assign diff = {comp_a[ELEM_WIDTH-1], comp_a} - {comp_b[ELEM_WIDTH-1], comp_b};
  assign diff_neg = -diff;
  assign mag = diff[DW-1] ? diff_neg[ELEM_WIDTH-1:0] : diff[ELEM_WIDTH-1:0];

  assign prod = mag1 * mag1;

  // Saturating accumulate: any carry above the sum width pins the sum at all ones.
  assign total = AW'(sum) + AW'(sq2);
  assign acc_sum = (|total[AW-1:SUM_W]) ? {SUM_W{1'b1}} : total[SUM_W-1:0];

  // The pipeline holds only when a finished sum finds the queue full.
  assign adv = !(v2 && last2 && q_stat.full);
  assign in_stall = !adv;
  assign push = v2 && last2 && !q_stat.full;
  assign push_data = acc_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      sum <= '0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      if (v2) begin
        sum <= last2 ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1 <= mag;
      last1 <= last_comp;
      sq2 <= prod;
      last2 <= last1;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("front pushed a sum into a full queue");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && v2 && last2) |=> (sum == '0))
    else $error("running sum not cleared after the last component");

  a_hold_square: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(sq2) && v2 && last2))
    else $error("square stage moved while the front was held");

endmodule

>>> hdl/eda_queue.sv
// Short queue of finished sums between the front end and the square-root back end.
`timescale 1ns / 1ps

module eda_queue
  import eda_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [SUM_W-1:0] push_data,
  input  logic             pop,
  output logic [SUM_W-1:0] head,
  output q_status_t        q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [SUM_W-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop = pop && !q_stat.empty;
  assign head = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds its depth");

endmodule

>>> hdl/eda_sqrt.sv
// Back end: digit-by-digit integer square root of each finished sum and the result register.
`timescale 1ns / 1ps

module eda_sqrt
  import eda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  q_status_t         q_stat,
  input  logic [SUM_W-1:0]  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SUM_W-1:0]  squared_distance,
  output logic [ROOT_W-1:0] distance
);

  localparam int RW = ROOT_W + 4;
  localparam int CW = $clog2(ROOT_W);
  localparam int XW = SUM_W + 1;

  back_state_t      state;
  back_state_t      state_next;
  logic             load_out;

  logic [SUM_W-1:0]  keep;
  logic [SUM_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [RW-1:0]     rem;
  logic [CW-1:0]     cnt;

  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic              ge;
  logic              last_step;

  // One result bit per cycle: bring down two radicand bits and try root*4+1.
  assign rem_sh = {rem[RW-3:0], rad[SUM_W-1 -: 2]};
  assign trial = RW'({root, 2'b01});
  assign ge = (rem_sh >= trial);
  assign last_step = (cnt == CW'(ROOT_W - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (pop) state_next = BK_RUN;
      BK_RUN:  if (last_step) state_next = BK_HOLD;
      BK_HOLD: if (load_out) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: pop = !q_stat.empty;
      BK_RUN:  ;
      BK_HOLD: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      keep <= head;
      rad <= head;
      root <= '0;
      rem <= '0;
      cnt <= '0;
    end else if (state == BK_RUN) begin
      rad <= {rad[SUM_W-3:0], 2'b00};
      rem <= ge ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
    if (load_out) begin
      squared_distance <= keep;
      distance <= root;
    end
  end

  a_root_exact: assert property (@(posedge clk) disable iff (rst)
    (state == BK_HOLD) |->
      ((XW'(root) * XW'(root) <= XW'(keep)) &&
       ((XW'(root) + 1'b1) * (XW'(root) + 1'b1) > XW'(keep))))
    else $error("square root is not the floor of the root of the sum");

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    pop |=> ((state == BK_RUN) && (cnt == '0)))
    else $error("root unit did not start after taking a sum");

endmodule

>>> hdl/euclidean_distance_accumulator.sv
// Top level of the Euclidean distance accumulator: front end, sum queue and square-root back end.
`timescale 1ns / 1ps

// Streams one pair of signed fixed-point components per transaction and adds the exact
// square of their difference to a 40-bit running sum that saturates at all ones. The
// transaction marked last_comp yields one result: the sum and the floor of its square
// root; the sum then clears. The front takes a transaction in every cycle that in_stall
// is low. When the root unit is free, the last accepted transaction goes through the
// square stage, the accumulate and queue write, the load of the root unit, 20 bit-serial
// root steps and the result register before out_valid rises. The root unit ends a sum
// before it takes the next; with out_stall low, vectors of at least 22 components stream
// at one transaction per cycle; shorter ones are held once the two-entry sum queue is full.
module euclidean_distance_accumulator
  import eda_pkg::*;
#(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ELEM_WIDTH-1:0] comp_a,
  input  logic [ELEM_WIDTH-1:0] comp_b,
  input  logic                  last_comp,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic [SUM_W-1:0]      squared_distance,
  output logic [ROOT_W-1:0]     distance,
  output logic                  out_valid,
  input  logic                  out_stall
);

  q_status_t        q_stat;
  logic             push;
  logic [SUM_W-1:0] push_data;
  logic             pop;
  logic [SUM_W-1:0] head;

  eda_front #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .comp_a(comp_a),
    .comp_b(comp_b),
    .last_comp(last_comp),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .q_stat(q_stat),
    .push(push),
    .push_data(push_data)
  );

  eda_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(pop),
    .head(head),
    .q_stat(q_stat)
  );

  eda_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .q_stat(q_stat),
    .head(head),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .squared_distance(squared_distance),
    .distance(distance)
  );

endmodule
